FILE: sv/elep_pkg.sv
`timescale 1ns / 1ps
// types, constants and saturating q16.16 arithmetic for the eigen projection core
// no dependencies

package elep_pkg;

	typedef logic signed [31:0] fx_t;

	typedef struct packed {
		logic f;
		fx_t  v;
	} res_t;

	localparam fx_t FX_ONE  = 32'sd65536;
	localparam fx_t FX_HALF = 32'sd32768;
	localparam fx_t FX_TWO  = 32'sd131072;

	localparam logic [17:0] GAMMA_RST = 18'd91750;

	localparam int DIV_W     = 48;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STG   = DIV_W / DIV_STEPS;
	localparam int DIV_LAT   = DIV_STG + 2;

	localparam int SQ_W     = 24;
	localparam int SQ_STEPS = 4;
	localparam int SQ_STG   = SQ_W / SQ_STEPS;
	localparam int SQ_LAT   = SQ_STG + 2;

	typedef struct packed {
		logic flt;
		fx_t rho; fx_t mx; fx_t my; fx_t mz; fx_t en;
		fx_t q1; fx_t q2; fx_t q3; fx_t q4; fx_t q5; fx_t g;
		fx_t u1; fx_t u2; fx_t u3;
		fx_t sq1; fx_t sq2; fx_t sq3; fx_t hr; fx_t gm1;
		fx_t mu2q3; fx_t mu3q4; fx_t mu2q1; fx_t mu3q1;
		fx_t umag2; fx_t t5; fx_t w3; fx_t w4;
		fx_t kin; fx_t s; fx_t uh; fx_t ek; fx_t press; fx_t gp; fx_t ep;
		fx_t h; fx_t ab; fx_t c;
		fx_t th; fx_t hmu; fx_t uc; fx_t cmu; fx_t cpu; fx_t hu1; fx_t cs;
		fx_t uhh; fx_t huh; fx_t mu1q2;
		fx_t d2; fx_t a1; fx_t a5; fx_t mb1; fx_t mb5; fx_t n2a;
		fx_t d1; fx_t b1; fx_t b5; fx_t aq1; fx_t aq5; fx_t n2b;
		fx_t bq1; fx_t bq5; fx_t n2c;
		fx_t n1x; fx_t n5x; fx_t n2d;
		fx_t n1; fx_t n5; fx_t n2e; fx_t n2f;
	} ctx_t;

	function automatic res_t fsat(input logic signed [63:0] v);
		res_t r;
		if (v > 64'sd2147483647) begin
			r.f = 1'b1;
			r.v = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r.f = 1'b1;
			r.v = 32'sh80000000;
		end else begin
			r.f = 1'b0;
			r.v = fx_t'(v[31:0]);
		end
		return r;
	endfunction

	function automatic res_t fadd(input fx_t a, input fx_t b);
		return fsat(64'(a) + 64'(b));
	endfunction

	function automatic res_t fsub(input fx_t a, input fx_t b);
		return fsat(64'(a) - 64'(b));
	endfunction

	function automatic res_t fmul(input fx_t a, input fx_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd32768;
		return fsat(p >>> 16);
	endfunction

	function automatic res_t fabsq(input fx_t a);
		logic signed [63:0] v;
		v = 64'(a);
		return fsat(a < 0 ? -v : v);
	endfunction

endpackage

FILE: sv/euler_left_eigen_projection_core.sv
`timescale 1ns / 1ps
// euler left eigenvector projection, 3-d, signed q16.16, fully pipelined
// depends on elep_pkg, elep_div, elep_sqrt
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// in       | start, busy        | avg_density..avg_energy, point_c1..c5
// out      | done               | char_w1..char_w5, math_fault
// config   | cfg_we             | cfg_data (gamma_ratio)
//
// one item per cycle, busy is always low
// latency is set by three chained 48-bit dividers (4 bits per stage) and the root unit
// arst_n clears the valid chain and loads the reset gamma
// done is high for one cycle with the result; results cannot be stalled

module euler_left_eigen_projection_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          cfg_we,
	input  logic [17:0]   cfg_data,
	input  elep_pkg::fx_t avg_density,
	input  elep_pkg::fx_t avg_momentum_x,
	input  elep_pkg::fx_t avg_momentum_y,
	input  elep_pkg::fx_t avg_momentum_z,
	input  elep_pkg::fx_t avg_energy,
	input  elep_pkg::fx_t point_c1,
	input  elep_pkg::fx_t point_c2,
	input  elep_pkg::fx_t point_c3,
	input  elep_pkg::fx_t point_c4,
	input  elep_pkg::fx_t point_c5,
	output logic          done,
	output elep_pkg::fx_t char_w1,
	output elep_pkg::fx_t char_w2,
	output elep_pkg::fx_t char_w3,
	output elep_pkg::fx_t char_w4,
	output elep_pkg::fx_t char_w5,
	output logic          math_fault
);
	import elep_pkg::*;

	localparam int P_S14 = 1 + DIV_LAT + 6 + DIV_LAT + 1 + SQ_LAT + 7;
	localparam int LAT   = P_S14 + DIV_LAT + 1;

	logic [17:0]    gamma_q;
	logic [LAT-1:0] vld_s;

	ctx_t ctx_s0, ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	ctx_t ctx_s8, ctx_s9, ctx_s10, ctx_s11, ctx_s12, ctx_s13, ctx_s14;
	ctx_t nx0, nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8, nx9, nx10, nx11, nx12, nx13, nx14;
	ctx_t dl1_s [DIV_LAT];
	ctx_t dl2_s [DIV_LAT];
	ctx_t dl3_s [SQ_LAT];
	ctx_t dl4_s [DIV_LAT];

	fx_t        dq1 [3];
	logic [2:0] dfl1;
	fx_t        dq2 [2];
	logic [1:0] dfl2;
	fx_t        dq3 [3];
	logic [2:0] dfl3;
	fx_t        sq_root;

	fx_t  w1_q, w2_q, w3_q, w4_q, w5_q;
	logic flt_q;

	logic [9:0] f1;
	logic [3:0] f2;
	logic [2:0] f3;
	logic       f4;
	logic       f5;
	logic [1:0] f6;
	logic       f7;
	logic [9:0] f8;
	logic [5:0] f9;
	logic [5:0] f10;
	logic [2:0] f11;
	logic [2:0] f12;
	logic [2:0] f13;
	logic       f14;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			vld_s   <= '0;
		end else begin
			if (cfg_we) begin
				gamma_q <= cfg_data;
			end
			vld_s <= {vld_s[LAT-2:0], start};
		end
	end

	always_comb begin
		nx0     = '0;
		nx0.rho = avg_density;
		nx0.mx  = avg_momentum_x;
		nx0.my  = avg_momentum_y;
		nx0.mz  = avg_momentum_z;
		nx0.en  = avg_energy;
		nx0.q1  = point_c1;
		nx0.q2  = point_c2;
		nx0.q3  = point_c3;
		nx0.q4  = point_c4;
		nx0.q5  = point_c5;
		nx0.g   = fx_t'({14'b0, gamma_q});
	end

	always_ff @(posedge clk) begin
		ctx_s0 <= nx0;
	end

	// velocities
	elep_div u_div_u1 (.clk(clk), .a(ctx_s0.mx), .b(ctx_s0.rho), .quo(dq1[0]), .flt(dfl1[0]));
	elep_div u_div_u2 (.clk(clk), .a(ctx_s0.my), .b(ctx_s0.rho), .quo(dq1[1]), .flt(dfl1[1]));
	elep_div u_div_u3 (.clk(clk), .a(ctx_s0.mz), .b(ctx_s0.rho), .quo(dq1[2]), .flt(dfl1[2]));

	always_comb begin
		nx1 = dl1_s[DIV_LAT-1];
		nx1.u1 = dq1[0];
		nx1.u2 = dq1[1];
		nx1.u3 = dq1[2];
		{f1[0], nx1.sq1}   = fmul(dq1[0], dq1[0]);
		{f1[1], nx1.sq2}   = fmul(dq1[1], dq1[1]);
		{f1[2], nx1.sq3}   = fmul(dq1[2], dq1[2]);
		{f1[3], nx1.hr}    = fmul(FX_HALF, nx1.rho);
		{f1[4], nx1.gm1}   = fsub(nx1.g, FX_ONE);
		{f1[5], nx1.mu2q3} = fmul(dq1[1], nx1.q3);
		{f1[6], nx1.mu3q4} = fmul(dq1[2], nx1.q4);
		{f1[7], nx1.mu2q1} = fmul(dq1[1], nx1.q1);
		{f1[8], nx1.mu3q1} = fmul(dq1[2], nx1.q1);
		f1[9] = |dfl1;
		nx1.flt = nx1.flt | (|f1);
	end

	always_comb begin
		nx2 = ctx_s1;
		{f2[0], nx2.umag2} = fadd(ctx_s1.sq1, ctx_s1.sq2);
		{f2[1], nx2.umag2} = fadd(nx2.umag2, ctx_s1.sq3);
		{f2[2], nx2.w3}    = fsub(ctx_s1.q3, ctx_s1.mu2q1);
		{f2[3], nx2.w4}    = fsub(ctx_s1.q4, ctx_s1.mu3q1);
		nx2.t5  = 32'(0);
		nx2.flt = nx2.flt | (|f2);
	end

	always_comb begin
		nx3 = ctx_s2;
		{f3[0], nx3.kin} = fmul(ctx_s2.hr, ctx_s2.umag2);
		{f3[1], nx3.t5}  = fsub(ctx_s2.q5, ctx_s2.mu2q3);
		{f3[2], nx3.uh}  = fmul(FX_HALF, ctx_s2.umag2);
		nx3.flt = nx3.flt | (|f3);
	end

	always_comb begin
		nx4 = ctx_s3;
		{f4, nx4.ek} = fsub(ctx_s3.en, ctx_s3.kin);
		{nx4.flt, nx4.s} = fsub(ctx_s3.t5, ctx_s3.mu3q4);
		nx4.flt = nx4.flt | f4 | ctx_s3.flt;
	end

	always_comb begin
		nx5 = ctx_s4;
		{f5, nx5.press} = fmul(ctx_s4.gm1, ctx_s4.ek);
		nx5.flt = nx5.flt | f5;
	end

	always_comb begin
		nx6 = ctx_s5;
		{f6[0], nx6.gp} = fmul(ctx_s5.g, ctx_s5.press);
		{f6[1], nx6.ep} = fadd(ctx_s5.en, ctx_s5.press);
		nx6.flt = nx6.flt | (|f6);
	end

	// sound speed argument and enthalpy
	elep_div u_div_gp (.clk(clk), .a(ctx_s6.gp), .b(ctx_s6.rho), .quo(dq2[0]), .flt(dfl2[0]));
	elep_div u_div_h  (.clk(clk), .a(ctx_s6.ep), .b(ctx_s6.rho), .quo(dq2[1]), .flt(dfl2[1]));

	always_comb begin
		nx7 = dl2_s[DIV_LAT-1];
		nx7.h = dq2[1];
		{f7, nx7.ab} = fabsq(dq2[0]);
		nx7.flt = nx7.flt | f7 | (|dfl2);
	end

	elep_sqrt u_sqrt (.clk(clk), .x(ctx_s7.ab), .root(sq_root));

	always_comb begin
		nx8 = dl3_s[SQ_LAT-1];
		nx8.c = sq_root;
		{f8[0], nx8.th}    = fmul(FX_TWO, nx8.h);
		{f8[1], nx8.hmu}   = fsub(nx8.h, nx8.umag2);
		{f8[2], nx8.uc}    = fmul(nx8.u1, sq_root);
		{f8[3], nx8.cmu}   = fsub(sq_root, nx8.u1);
		{f8[4], nx8.cpu}   = fadd(sq_root, nx8.u1);
		{f8[5], nx8.hu1}   = fmul(nx8.h, nx8.u1);
		{f8[6], nx8.cs}    = fmul(sq_root, nx8.s);
		{f8[7], nx8.uhh}   = fsub(nx8.uh, nx8.h);
		{f8[8], nx8.huh}   = fsub(nx8.h, nx8.uh);
		{f8[9], nx8.mu1q2} = fmul(nx8.u1, nx8.q2);
		nx8.flt = nx8.flt | (|f8);
	end

	always_comb begin
		nx9 = ctx_s8;
		{f9[0], nx9.d2}  = fsub(ctx_s8.th, ctx_s8.umag2);
		{f9[1], nx9.a1}  = fsub(ctx_s8.uhh, ctx_s8.uc);
		{f9[2], nx9.a5}  = fsub(ctx_s8.huh, ctx_s8.uc);
		{f9[3], nx9.mb1} = fmul(ctx_s8.uh, ctx_s8.cmu);
		{f9[4], nx9.mb5} = fmul(ctx_s8.uh, ctx_s8.cpu);
		{f9[5], nx9.n2a} = fmul(ctx_s8.hmu, ctx_s8.q1);
		nx9.flt = nx9.flt | (|f9);
	end

	always_comb begin
		nx10 = ctx_s9;
		{f10[0], nx10.d1}  = fmul(ctx_s9.c, ctx_s9.d2);
		{f10[1], nx10.b1}  = fadd(ctx_s9.mb1, ctx_s9.hu1);
		{f10[2], nx10.b5}  = fsub(ctx_s9.mb5, ctx_s9.hu1);
		{f10[3], nx10.aq1} = fmul(ctx_s9.a1, ctx_s9.q2);
		{f10[4], nx10.aq5} = fmul(ctx_s9.a5, ctx_s9.q2);
		{f10[5], nx10.n2b} = fadd(ctx_s9.n2a, ctx_s9.mu1q2);
		nx10.flt = nx10.flt | (|f10);
	end

	always_comb begin
		nx11 = ctx_s10;
		{f11[0], nx11.bq1} = fmul(ctx_s10.b1, ctx_s10.q1);
		{f11[1], nx11.bq5} = fmul(ctx_s10.b5, ctx_s10.q1);
		{f11[2], nx11.n2c} = fadd(ctx_s10.n2b, ctx_s10.mu2q3);
		nx11.flt = nx11.flt | (|f11);
	end

	always_comb begin
		nx12 = ctx_s11;
		{f12[0], nx12.n1x} = fadd(ctx_s11.aq1, ctx_s11.bq1);
		{f12[1], nx12.n5x} = fadd(ctx_s11.aq5, ctx_s11.bq5);
		{f12[2], nx12.n2d} = fadd(ctx_s11.n2c, ctx_s11.mu3q4);
		nx12.flt = nx12.flt | (|f12);
	end

	always_comb begin
		nx13 = ctx_s12;
		{f13[0], nx13.n1}  = fadd(ctx_s12.n1x, ctx_s12.cs);
		{f13[1], nx13.n5}  = fadd(ctx_s12.n5x, ctx_s12.cs);
		{f13[2], nx13.n2e} = fsub(ctx_s12.n2d, ctx_s12.q5);
		nx13.flt = nx13.flt | (|f13);
	end

	always_comb begin
		nx14 = ctx_s13;
		{f14, nx14.n2f} = fmul(FX_TWO, ctx_s13.n2e);
		nx14.flt = nx14.flt | f14;
	end

	// characteristic quotients
	elep_div u_div_w1 (.clk(clk), .a(ctx_s14.n1),  .b(ctx_s14.d1), .quo(dq3[0]), .flt(dfl3[0]));
	elep_div u_div_w2 (.clk(clk), .a(ctx_s14.n2f), .b(ctx_s14.d2), .quo(dq3[1]), .flt(dfl3[1]));
	elep_div u_div_w5 (.clk(clk), .a(ctx_s14.n5),  .b(ctx_s14.d1), .quo(dq3[2]), .flt(dfl3[2]));

	always_ff @(posedge clk) begin
		dl1_s[0] <= ctx_s0;
		dl2_s[0] <= ctx_s6;
		dl3_s[0] <= ctx_s7;
		dl4_s[0] <= ctx_s14;
		for (int k = 1; k < DIV_LAT; k++) begin
			dl1_s[k] <= dl1_s[k-1];
			dl2_s[k] <= dl2_s[k-1];
			dl4_s[k] <= dl4_s[k-1];
		end
		for (int k = 1; k < SQ_LAT; k++) begin
			dl3_s[k] <= dl3_s[k-1];
		end
		ctx_s1  <= nx1;
		ctx_s2  <= nx2;
		ctx_s3  <= nx3;
		ctx_s4  <= nx4;
		ctx_s5  <= nx5;
		ctx_s6  <= nx6;
		ctx_s7  <= nx7;
		ctx_s8  <= nx8;
		ctx_s9  <= nx9;
		ctx_s10 <= nx10;
		ctx_s11 <= nx11;
		ctx_s12 <= nx12;
		ctx_s13 <= nx13;
		ctx_s14 <= nx14;
		w1_q  <= dq3[0];
		w2_q  <= dq3[1];
		w5_q  <= dq3[2];
		w3_q  <= dl4_s[DIV_LAT-1].w3;
		w4_q  <= dl4_s[DIV_LAT-1].w4;
		flt_q <= dl4_s[DIV_LAT-1].flt | (|dfl3);
	end

	assign done       = vld_s[LAT-1];
	assign char_w1    = w1_q;
	assign char_w2    = w2_q;
	assign char_w3    = w3_q;
	assign char_w4    = w4_q;
	assign char_w5    = w5_q;
	assign math_fault = flt_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done)
		else $error("item did not complete at the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s[P_S14-1], DIV_LAT + 1))
		else $error("result without an item in the last divider stage");

	a_root_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!sq_root[31])
		else $error("sound speed negative");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[P_S14-1] && ctx_s14.d1 == 0) |-> ##(DIV_LAT + 1) (done && math_fault))
		else $error("zero divisor not flagged");
`endif

endmodule

FILE: sv/elep_div.sv
`timescale 1ns / 1ps
// pipelined q16.16 divider, quotient truncated toward zero and saturated
// depends on elep_pkg

module elep_div (
	input  logic           clk,
	input  elep_pkg::fx_t  a,
	input  elep_pkg::fx_t  b,
	output elep_pkg::fx_t  quo,
	output logic           flt
);
	import elep_pkg::*;

	typedef struct packed {
		logic [31:0]      rem;
		logic [DIV_W-1:0] nq;
		logic [31:0]      d;
		logic             neg;
		logic             dz;
	} dst_t;

	function automatic dst_t div_step(input dst_t s);
		dst_t r;
		logic [32:0] t;
		r = s;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.nq[DIV_W-1]};
			r.nq = {r.nq[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, r.d}) begin
				t = t - {1'b0, r.d};
				r.nq[0] = 1'b1;
			end
			r.rem = t[31:0];
		end
		return r;
	endfunction

	dst_t        pipe_s [DIV_STG+1];
	dst_t        entry;
	logic [31:0] ua;
	logic [31:0] ub;
	fx_t         quo_nx;
	logic        flt_nx;
	fx_t         quo_s;
	logic        flt_s;

	always_comb begin
		ua = a[31] ? 32'(-a) : 32'(a);
		ub = b[31] ? 32'(-b) : 32'(b);
		entry.rem = '0;
		entry.nq  = {ua, 16'b0};
		entry.d   = ub;
		entry.neg = a[31] ^ b[31];
		entry.dz  = (b == 0);
	end

	always_comb begin
		if (pipe_s[DIV_STG].dz) begin
			quo_nx = '0;
			flt_nx = 1'b1;
		end else if (!pipe_s[DIV_STG].neg) begin
			if (pipe_s[DIV_STG].nq > DIV_W'(32'h7fffffff)) begin
				quo_nx = 32'sh7fffffff;
				flt_nx = 1'b1;
			end else begin
				quo_nx = fx_t'(pipe_s[DIV_STG].nq[31:0]);
				flt_nx = 1'b0;
			end
		end else begin
			if (pipe_s[DIV_STG].nq > DIV_W'(32'h80000000)) begin
				quo_nx = 32'sh80000000;
				flt_nx = 1'b1;
			end else begin
				quo_nx = fx_t'(-pipe_s[DIV_STG].nq[31:0]);
				flt_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= entry;
		for (int k = 0; k < DIV_STG; k++) begin
			pipe_s[k+1] <= div_step(pipe_s[k]);
		end
		quo_s <= quo_nx;
		flt_s <= flt_nx;
	end

	assign quo = quo_s;
	assign flt = flt_s;

endmodule

FILE: sv/elep_sqrt.sv
`timescale 1ns / 1ps
// pipelined q16.16 square root, digit by digit, zero for non-positive input
// depends on elep_pkg

module elep_sqrt (
	input  logic          clk,
	input  elep_pkg::fx_t x,
	output elep_pkg::fx_t root
);
	import elep_pkg::*;

	typedef struct packed {
		logic [SQ_W+1:0]   rem;
		logic [SQ_W-1:0]   rt;
		logic [2*SQ_W-1:0] n;
	} sst_t;

	function automatic sst_t sq_step(input sst_t s);
		sst_t r;
		logic [SQ_W+3:0] t;
		logic [SQ_W+3:0] tr;
		r = s;
		for (int i = 0; i < SQ_STEPS; i++) begin
			t = {r.rem, r.n[2*SQ_W-1:2*SQ_W-2]};
			tr = {2'b00, r.rt, 2'b01};
			r.n = {r.n[2*SQ_W-3:0], 2'b00};
			if (t >= tr) begin
				t = t - tr;
				r.rt = {r.rt[SQ_W-2:0], 1'b1};
			end else begin
				r.rt = {r.rt[SQ_W-2:0], 1'b0};
			end
			r.rem = t[SQ_W+1:0];
		end
		return r;
	endfunction

	sst_t pipe_s [SQ_STG+1];
	sst_t entry;
	fx_t  root_s;

	always_comb begin
		entry.rem = '0;
		entry.rt  = '0;
		entry.n   = (x <= 0) ? '0 : {1'b0, x[30:0], 16'b0};
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= entry;
		for (int k = 0; k < SQ_STG; k++) begin
			pipe_s[k+1] <= sq_step(pipe_s[k]);
		end
		root_s <= fx_t'({8'b0, pipe_s[SQ_STG].rt});
	end

	assign root = root_s;

endmodule
